>>> hw/rtl/ffsa_pkg.sv
// Package for the first-fit span allocator: field widths, reset values,
// operation codes, controller states and the structs shared by the cells.
// No dependencies.
package ffsa_pkg;

  localparam int MAX_SPANS_DEF = 32;
  localparam int POS_W   = 17;
  localparam int TAG_W   = 16;
  localparam int CH_W    = 14;
  localparam int OFF_W   = 30;
  localparam int LIVE_W  = 6;
  localparam int PROD_W  = POS_W + CH_W;

  localparam logic [CH_W-1:0]  CHANNELS_RST = CH_W'(128);
  localparam logic [POS_W-1:0] POOL_RST     = POS_W'(4096);

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic {
    REG_CHANNELS = 1'b0,
    REG_POOL     = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_LOAD1,
    ST_SCAN1,
    ST_LOAD2,
    ST_SCAN2,
    ST_DECIDE,
    ST_MUL,
    ST_FINISH
  } state_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             load1;
    logic             load2;
    logic             shift;
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pool;
    logic [POS_W-1:0] wstart;
    logic [POS_W-1:0] wstop;
  } cmd_t;

  // Span copy that circulates around the ring.
  typedef struct packed {
    logic             valid;
    logic             fit;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] stop;
  } ring_t;

  function automatic logic [POS_W-1:0] sat_gap(input logic [POS_W-1:0] hi,
                                                input logic [POS_W-1:0] lo);
    sat_gap = (hi > lo) ? hi - lo : '0;
  endfunction

endpackage

>>> hw/rtl/ffsa_cell.sv
// One span slot of the allocator ring: holds the span, a circulating copy
// stage, and tracks the start of its successor in start order.
// Depends on ffsa_pkg.
module ffsa_cell #(
  parameter int N    = ffsa_pkg::MAX_SPANS_DEF,
  parameter int SLOT = 0,
  localparam int SLOT_W = (N > 1) ? $clog2(N) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ffsa_pkg::cmd_t           cmd,
  input  logic                     wr,
  input  logic                     clr,
  input  ffsa_pkg::ring_t          ring_in,
  input  logic [SLOT_W-1:0]        ring_in_slot,
  output ffsa_pkg::ring_t          ring_out,
  output logic [SLOT_W-1:0]        ring_out_slot,
  output logic                     valid,
  output logic                     hit
);
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT);

  logic [ffsa_pkg::TAG_W-1:0] tag;
  logic [ffsa_pkg::POS_W-1:0] start;
  logic [ffsa_pkg::POS_W-1:0] stop;
  logic                       succ_valid;
  logic [ffsa_pkg::POS_W-1:0] succ_start;
  ffsa_pkg::ring_t            rot;
  logic [SLOT_W-1:0]          rot_slot;
  logic                       later;
  logic                       fit;

  assign hit = valid && (tag == cmd.tag);

  // Copy in ring lies after this span in start order (ties by slot).
  assign later = rot.valid && ((rot.start > start) ||
                 ((rot.start == start) && (rot_slot > MY_SLOT)));

  always_comb begin
    if (succ_valid) begin
      fit = valid && (ffsa_pkg::sat_gap(succ_start, stop) >= cmd.len);
    end else begin
      fit = valid && (ffsa_pkg::sat_gap(cmd.pool, stop) >= cmd.len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end else if (clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      tag   <= cmd.tag;
      start <= cmd.wstart;
      stop  <= cmd.wstop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      succ_valid <= 1'b0;
    end else if (cmd.load1) begin
      succ_valid <= 1'b0;
    end else if (cmd.shift && later && (!succ_valid || rot.start < succ_start)) begin
      succ_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift && later && (!succ_valid || rot.start < succ_start)) begin
      succ_start <= rot.start;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load1 || cmd.load2) begin
      rot.valid <= valid;
      rot.fit   <= cmd.load2 && fit;
      rot.start <= start;
      rot.stop  <= stop;
      rot_slot  <= MY_SLOT;
    end else if (cmd.shift) begin
      rot      <= ring_in;
      rot_slot <= ring_in_slot;
    end
  end

  assign ring_out      = rot;
  assign ring_out_slot = rot_slot;

endmodule

>>> hw/rtl/first_fit_span_allocator_core.sv
// Top level of the first-fit span allocator: stream ports, APB registers,
// controller and the ring of span cells. Depends on ffsa_pkg, ffsa_cell.
// Throughput: one item at a time; the next beat is taken once the result is
// registered. An allocate walks the span copies twice around the cell ring;
// a free, or an allocate with no matching tag and no empty slot, skips the walk.
// Reset: synchronous, clears all span valid marks, registers to defaults.
module first_fit_span_allocator_core #(
  parameter int MAX_SPANS = ffsa_pkg::MAX_SPANS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // request_tag[15:0], span_length[32:16], zero pad
  input  logic [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // success[0], start_offset[30:1], live_count[36:31], pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int N      = MAX_SPANS;
  localparam int SLOT_W = (N > 1) ? $clog2(N) : 1;
  localparam int CNT_W  = $clog2(N + 1);
  localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(N - 1);
  localparam int POS_W  = ffsa_pkg::POS_W;

  // Configuration registers.
  logic [ffsa_pkg::CH_W-1:0] channels;
  logic [POS_W-1:0]          pool_length;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels    <= ffsa_pkg::CHANNELS_RST;
      pool_length <= ffsa_pkg::POOL_RST;
    end else if (cfg_wr) begin
      unique case (ffsa_pkg::reg_idx_t'(paddr[2]))
        ffsa_pkg::REG_CHANNELS: channels    <= pwdata[ffsa_pkg::CH_W-1:0];
        ffsa_pkg::REG_POOL:     pool_length <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ffsa_pkg::reg_idx_t'(paddr[2]))
      ffsa_pkg::REG_CHANNELS: prdata = 32'(channels);
      ffsa_pkg::REG_POOL:     prdata = 32'(pool_length);
      default:                prdata = '0;
    endcase
  end

  // Controller state.
  ffsa_pkg::state_t state, state_next;
  logic [SLOT_W-1:0]          step;
  ffsa_pkg::kind_t            op_kind;
  logic [ffsa_pkg::TAG_W-1:0] op_tag;
  logic [POS_W-1:0]           op_len;
  logic [SLOT_W-1:0]          target;
  logic                       target_hit;
  logic                       ok;
  logic [POS_W-1:0]           pos;
  logic [ffsa_pkg::PROD_W-1:0] prod;
  logic [CNT_W-1:0]           count, count_next;

  // Trackers fed by the copy passing cell 0.
  logic                       any_valid;
  logic [POS_W-1:0]           min_start;
  logic                       best_valid;
  logic [POS_W-1:0]           best_start;
  logic [SLOT_W-1:0]          best_slot;
  logic [POS_W-1:0]           best_stop;

  // Ring wiring.
  ffsa_pkg::cmd_t    cmd;
  ffsa_pkg::ring_t   ring   [N];
  logic [SLOT_W-1:0] rslot  [N];
  logic [N-1:0]      valid_vec, hit_vec, wr_vec, clr_vec;

  logic              hit_any, free_any, emit, head_fit;
  logic [SLOT_W-1:0] hit_idx, free_idx;

  assign s_tready = (state == ffsa_pkg::ST_IDLE);
  assign emit     = (state == ffsa_pkg::ST_FINISH) && (!m_tvalid || m_tready);

  // Tag lookup and first empty slot; tags are unique among live spans.
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_vec[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign head_fit = any_valid ? (min_start >= op_len) : (pool_length >= op_len);

  always_comb begin
    cmd.load1  = (state == ffsa_pkg::ST_LOAD1);
    cmd.load2  = (state == ffsa_pkg::ST_LOAD2);
    cmd.shift  = (state == ffsa_pkg::ST_SCAN1) || (state == ffsa_pkg::ST_SCAN2);
    cmd.tag    = op_tag;
    cmd.len    = op_len;
    cmd.pool   = pool_length;
    cmd.wstart = pos;
    cmd.wstop  = pos + op_len;
    for (int i = 0; i < N; i++) begin
      wr_vec[i]  = emit && ok && (op_kind == ffsa_pkg::KIND_ALLOC) && (target == SLOT_W'(i));
      clr_vec[i] = emit && ok && (op_kind == ffsa_pkg::KIND_FREE)  && (target == SLOT_W'(i));
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ffsa_pkg::ST_IDLE:   if (s_tvalid) state_next = ffsa_pkg::ST_LOOK;
      ffsa_pkg::ST_LOOK: begin
        if (op_kind == ffsa_pkg::KIND_FREE || (!hit_any && !free_any)) begin
          state_next = ffsa_pkg::ST_FINISH;
        end else begin
          state_next = ffsa_pkg::ST_LOAD1;
        end
      end
      ffsa_pkg::ST_LOAD1:  state_next = ffsa_pkg::ST_SCAN1;
      ffsa_pkg::ST_SCAN1:  if (step == LAST_STEP) state_next = ffsa_pkg::ST_LOAD2;
      ffsa_pkg::ST_LOAD2:  state_next = ffsa_pkg::ST_SCAN2;
      ffsa_pkg::ST_SCAN2:  if (step == LAST_STEP) state_next = ffsa_pkg::ST_DECIDE;
      ffsa_pkg::ST_DECIDE: state_next = ffsa_pkg::ST_MUL;
      ffsa_pkg::ST_MUL:    state_next = ffsa_pkg::ST_FINISH;
      ffsa_pkg::ST_FINISH: if (emit) state_next = ffsa_pkg::ST_IDLE;
      default:             state_next = ffsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the item, pick the slot, walk the ring.
  always_ff @(posedge clk) begin
    if (state == ffsa_pkg::ST_IDLE && s_tvalid) begin
      op_kind <= ffsa_pkg::kind_t'(s_tuser[0]);
      op_tag  <= s_tdata[15:0];
      op_len  <= s_tdata[32:16];
    end
    if (state == ffsa_pkg::ST_LOOK) begin
      target_hit <= hit_any;
      pos        <= '0;
      if (op_kind == ffsa_pkg::KIND_FREE) begin
        target <= hit_idx;
        ok     <= hit_any;
      end else begin
        target <= hit_any ? hit_idx : free_idx;
        ok     <= 1'b0;
      end
    end
    if (state == ffsa_pkg::ST_LOAD1 || state == ffsa_pkg::ST_LOAD2) begin
      step <= '0;
    end else if (cmd.shift) begin
      step <= step + 1'b1;
    end
    // Head gap lies before the first span in start order.
    if (state == ffsa_pkg::ST_LOAD1) begin
      any_valid <= 1'b0;
    end else if (state == ffsa_pkg::ST_SCAN1 && ring[0].valid &&
                 (!any_valid || ring[0].start < min_start)) begin
      any_valid <= 1'b1;
      min_start <= ring[0].start;
    end
    // Earliest span in start order (ties by slot) whose trailing gap holds the length.
    if (state == ffsa_pkg::ST_LOAD2) begin
      best_valid <= 1'b0;
    end else if (state == ffsa_pkg::ST_SCAN2 && ring[0].fit &&
                 (!best_valid || ring[0].start < best_start ||
                  (ring[0].start == best_start && rslot[0] < best_slot))) begin
      best_valid <= 1'b1;
      best_start <= ring[0].start;
      best_slot  <= rslot[0];
      best_stop  <= ring[0].stop;
    end
    if (state == ffsa_pkg::ST_DECIDE) begin
      ok  <= head_fit || best_valid;
      pos <= head_fit ? '0 : best_stop;
    end
    if (state == ffsa_pkg::ST_MUL) begin
      prod <= pos * channels;
    end
  end

  // Live span count follows every write and clear.
  always_comb begin
    count_next = count;
    if (emit && ok) begin
      if (op_kind == ffsa_pkg::KIND_FREE) begin
        count_next = count - 1'b1;
      end else if (!target_hit) begin
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register; holds until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata[0]     <= ok;
      m_tdata[30:1]  <= (ok && op_kind == ffsa_pkg::KIND_ALLOC) ?
                        prod[ffsa_pkg::OFF_W-1:0] : '0;
      m_tdata[36:31] <= ffsa_pkg::LIVE_W'(count_next);
      m_tdata[39:37] <= '0;
    end
  end

  // Ring of cells; each copy advances toward cell 0.
  for (genvar g = 0; g < N; g++) begin : g_cell
    ffsa_cell #(
      .N    (N),
      .SLOT (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .wr            (wr_vec[g]),
      .clr           (clr_vec[g]),
      .ring_in       (ring[(g + 1) % N]),
      .ring_in_slot  (rslot[(g + 1) % N]),
      .ring_out      (ring[g]),
      .ring_out_slot (rslot[g]),
      .valid         (valid_vec[g]),
      .hit           (hit_vec[g])
    );
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("live count disagrees with valid marks");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= N)
    else $error("live count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_free_target_live: assert property (@(posedge clk) disable iff (rst)
    emit && ok && op_kind == ffsa_pkg::KIND_FREE |-> valid_vec[target])
    else $error("free of a slot that is not live");

endmodule
